### design/orm_pkg.sv
`default_nettype none
package orm_pkg;

    localparam int ID_W  = 10;
    localparam int LEAF_IN_W = 10;
    localparam int WORD_W = 64;

    localparam int DEF_TREE_DEPTH   = 10;
    localparam int DEF_BUCKET_SLOTS = 4;
    localparam int DEF_BLOCK_COUNT  = 1024;
    localparam int DEF_STASH_DEPTH  = 64;
    localparam int DEF_DATA_WIDTH   = 64;

    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_SET_PM = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]           action;
        logic [ID_W-1:0]      block_addr;
        logic [WORD_W-1:0]    write_data;
        logic [LEAF_IN_W-1:0] new_leaf;
    } orm_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              found;
        logic              stash_overflow;
    } orm_res_t;

endpackage
`default_nettype wire

### design/orm_ram.sv
`default_nettype none
module orm_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### design/orm_engine.sv
`default_nettype none
module orm_engine #(
    parameter int TREE_DEPTH   = orm_pkg::DEF_TREE_DEPTH,
    parameter int BUCKET_SLOTS = orm_pkg::DEF_BUCKET_SLOTS,
    parameter int BLOCK_COUNT  = orm_pkg::DEF_BLOCK_COUNT,
    parameter int STASH_DEPTH  = orm_pkg::DEF_STASH_DEPTH,
    parameter int DATA_WIDTH   = orm_pkg::DEF_DATA_WIDTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire orm_pkg::orm_req_t req,
    output logic                  ready,
    input  wire logic             out_free,
    output logic                  done,
    output orm_pkg::orm_res_t     res
);
    import orm_pkg::*;

    localparam int LW        = TREE_DEPTH;
    localparam int NW        = TREE_DEPTH + 1;
    localparam int XW        = NW + 4;
    localparam int PATH_LEN  = TREE_DEPTH + 1;
    localparam int NODE_CNT  = (2 << TREE_DEPTH) - 1;
    localparam int SLOT_CNT  = NODE_CNT * BUCKET_SLOTS;
    localparam int SA_W      = $clog2(SLOT_CNT);
    localparam int LVL_W     = $clog2(PATH_LEN + 1);
    localparam int FW        = $clog2(BUCKET_SLOTS + 1);
    localparam int PM_AW     = $clog2(BLOCK_COUNT);
    localparam int ST_AW     = $clog2(STASH_DEPTH);
    localparam int ST_CW     = $clog2(STASH_DEPTH + 1);
    localparam int WORK_DEPTH = STASH_DEPTH + PATH_LEN * BUCKET_SLOTS + 1;
    localparam int WK_AW     = $clog2(WORK_DEPTH);
    localparam int WK_CW     = $clog2(WORK_DEPTH + 1);
    localparam int CLR_N     = (SLOT_CNT > BLOCK_COUNT) ? SLOT_CNT : BLOCK_COUNT;
    localparam int CLR_W     = $clog2(CLR_N);
    localparam int DW        = DATA_WIDTH;
    localparam int ENT_W     = ID_W + DW;
    localparam int TR_W      = 1 + ID_W + DW;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PM    = 3'd2;
    localparam logic [2:0] S_STASH = 3'd3;
    localparam logic [2:0] S_PATH  = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_EVICT = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    function automatic logic [SA_W-1:0] slot_addr(input logic [LW-1:0] leaf,
                                                  input logic [LVL_W-1:0] lvl,
                                                  input logic [FW-1:0] slot);
        logic [NW-1:0] node;
        logic [XW-1:0] full;
        node = ({1'b1, leaf} >> lvl) - NW'(1);
        full = XW'(node) * XW'(BUCKET_SLOTS) + XW'(slot);
        return full[SA_W-1:0];
    endfunction

    function automatic logic [PM_AW-1:0] pm_index(input logic [ID_W-1:0] id);
        logic [ID_W+PM_AW-1:0] t;
        t = {{PM_AW{1'b0}}, id};
        return t[PM_AW-1:0];
    endfunction

    logic [2:0]       state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    orm_req_t         req_reg, req_next;
    logic [LW-1:0]    prev_leaf_reg, prev_leaf_next;
    logic [WK_CW-1:0] k_reg, k_next, wn_reg, wn_next, j_reg, j_next;
    logic             pend_reg, pend_next, pend2_reg, pend2_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [FW-1:0]    slot_reg, slot_next;
    logic             pdone_reg, pdone_next;
    logic [SA_W-1:0]  tr_pa_reg, tr_pa_next;
    logic             found_reg, found_next, ovf_reg, ovf_next;
    logic [DW-1:0]    rd_reg, rd_next;
    logic [ST_CW-1:0] scnt_reg, scnt_next;
    logic [FW-1:0]    fill_reg [PATH_LEN];
    logic [FW-1:0]    fill_next [PATH_LEN];
    logic [ID_W-1:0]  ev_id_reg, ev_id_next;
    logic [DW-1:0]    ev_data_reg, ev_data_next;

    logic             pm_we;
    logic [PM_AW-1:0] pm_waddr, pm_raddr;
    logic [LW-1:0]    pm_wdata, pm_rdata;
    logic             tr_we;
    logic [SA_W-1:0]  tr_waddr, tr_raddr;
    logic [TR_W-1:0]  tr_wdata, tr_rdata;
    logic             st_we;
    logic [ST_AW-1:0] st_waddr, st_raddr;
    logic [ENT_W-1:0] st_wdata, st_rdata;
    logic             wk_we;
    logic [WK_AW-1:0] wk_waddr, wk_raddr;
    logic [ENT_W-1:0] wk_wdata, wk_rdata;

    logic [LW+LEAF_IN_W-1:0] leaf_ext;
    logic [LW-1:0]           leaf_in;
    logic [DW-1:0]           wr_data;
    logic [DW+WORD_W-1:0]    rd_ext;
    logic                    placed;
    logic [LVL_W-1:0]        sel;
    logic [ID_W-1:0]         wk_id;
    logic [DW-1:0]           wk_dat;

    orm_ram #(.DEPTH(BLOCK_COUNT), .WIDTH(LW)) u_posmap (
        .aclk(aclk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .raddr(pm_raddr), .rdata(pm_rdata)
    );
    orm_ram #(.DEPTH(SLOT_CNT), .WIDTH(TR_W)) u_tree (
        .aclk(aclk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
        .raddr(tr_raddr), .rdata(tr_rdata)
    );
    orm_ram #(.DEPTH(STASH_DEPTH), .WIDTH(ENT_W)) u_stash (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );
    orm_ram #(.DEPTH(WORK_DEPTH), .WIDTH(ENT_W)) u_work (
        .aclk(aclk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
        .raddr(wk_raddr), .rdata(wk_rdata)
    );

    assign leaf_ext = {{LW{1'b0}}, req.new_leaf};
    assign leaf_in  = leaf_ext[LW-1:0];
    assign wr_data  = req_reg.write_data[DW-1:0];
    assign wk_id    = wk_rdata[ENT_W-1:DW];
    assign wk_dat   = wk_rdata[DW-1:0];
    assign rd_ext   = {{WORD_W{1'b0}}, rd_reg};

    assign ready              = (state_reg == S_IDLE);
    assign done               = (state_reg == S_DONE) && out_free;
    assign res.read_data      = rd_ext[WORD_W-1:0];
    assign res.found          = found_reg;
    assign res.stash_overflow = ovf_reg;

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        req_next       = req_reg;
        prev_leaf_next = prev_leaf_reg;
        k_next         = k_reg;
        wn_next        = wn_reg;
        j_next         = j_reg;
        pend_next      = pend_reg;
        pend2_next     = pend2_reg;
        lvl_next       = lvl_reg;
        slot_next      = slot_reg;
        pdone_next     = pdone_reg;
        tr_pa_next     = tr_pa_reg;
        found_next     = found_reg;
        ovf_next       = ovf_reg;
        rd_next        = rd_reg;
        scnt_next      = scnt_reg;
        fill_next      = fill_reg;
        ev_id_next     = ev_id_reg;
        ev_data_next   = ev_data_reg;
        pm_we = 1'b0; pm_waddr = '0; pm_wdata = '0; pm_raddr = '0;
        tr_we = 1'b0; tr_waddr = '0; tr_wdata = '0; tr_raddr = '0;
        st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_raddr = '0;
        wk_we = 1'b0; wk_waddr = '0; wk_wdata = '0; wk_raddr = '0;
        placed = 1'b0;
        sel    = '0;

        unique case (state_reg)
            S_CLEAR: begin
                pm_waddr = clr_reg[PM_AW-1:0];
                pm_we    = (32'(clr_reg) < BLOCK_COUNT);
                tr_waddr = clr_reg[SA_W-1:0];
                tr_we    = (32'(clr_reg) < SLOT_CNT);
                clr_next = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_W'(CLR_N - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    req_next   = req;
                    found_next = 1'b0;
                    ovf_next   = 1'b0;
                    rd_next    = '0;
                    if (32'(req.block_addr) >= BLOCK_COUNT || req.action == ACT_NONE) begin
                        state_next = S_DONE;
                    end else if (req.action == ACT_SET_PM) begin
                        pm_we      = 1'b1;
                        pm_waddr   = pm_index(req.block_addr);
                        pm_wdata   = leaf_in;
                        state_next = S_DONE;
                    end else begin
                        // read old leaf and remap in the same cycle
                        pm_raddr   = pm_index(req.block_addr);
                        pm_we      = 1'b1;
                        pm_waddr   = pm_index(req.block_addr);
                        pm_wdata   = leaf_in;
                        state_next = S_PM;
                    end
                end
            end
            S_PM: begin
                prev_leaf_next = pm_rdata;
                k_next         = '0;
                wn_next        = '0;
                pend_next      = 1'b0;
                state_next     = S_STASH;
            end
            S_STASH: begin
                if (pend_reg) begin
                    wk_we    = 1'b1;
                    wk_waddr = wn_reg[WK_AW-1:0];
                    wk_wdata = st_rdata;
                    wn_next  = wn_reg + WK_CW'(1);
                end
                if (k_reg < WK_CW'(scnt_reg)) begin
                    st_raddr  = k_reg[ST_AW-1:0];
                    k_next    = k_reg + WK_CW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        lvl_next   = '0;
                        slot_next  = '0;
                        pdone_next = 1'b0;
                        state_next = S_PATH;
                    end
                end
            end
            S_PATH: begin
                if (pend_reg) begin
                    tr_we    = 1'b1;
                    tr_waddr = tr_pa_reg;
                    if (tr_rdata[TR_W-1] && wn_reg < WK_CW'(WORK_DEPTH)) begin
                        wk_we    = 1'b1;
                        wk_waddr = wn_reg[WK_AW-1:0];
                        wk_wdata = tr_rdata[ENT_W-1:0];
                        wn_next  = wn_reg + WK_CW'(1);
                    end
                end
                if (!pdone_reg) begin
                    tr_raddr   = slot_addr(prev_leaf_reg, lvl_reg, slot_reg);
                    tr_pa_next = tr_raddr;
                    pend_next  = 1'b1;
                    if (slot_reg == FW'(BUCKET_SLOTS - 1)) begin
                        slot_next = '0;
                        if (lvl_reg == LVL_W'(PATH_LEN - 1)) begin
                            pdone_next = 1'b1;
                        end else begin
                            lvl_next = lvl_reg + LVL_W'(1);
                        end
                    end else begin
                        slot_next = slot_reg + FW'(1);
                    end
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        k_next     = '0;
                        j_next     = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (pend_reg) begin
                    if (wk_id == req_reg.block_addr) begin
                        if (!found_reg) begin
                            found_next = 1'b1;
                            rd_next    = wk_dat;
                        end
                    end else if (req_reg.action == ACT_WRITE) begin
                        // compact the survivors toward the front
                        wk_we    = 1'b1;
                        wk_waddr = j_reg[WK_AW-1:0];
                        wk_wdata = wk_rdata;
                        j_next   = j_reg + WK_CW'(1);
                    end
                end
                if (k_reg < wn_reg) begin
                    wk_raddr  = k_reg[WK_AW-1:0];
                    k_next    = k_reg + WK_CW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (req_reg.action == ACT_WRITE) begin
                            rd_next = wr_data;
                            if (j_reg < WK_CW'(WORK_DEPTH)) begin
                                wk_we    = 1'b1;
                                wk_waddr = j_reg[WK_AW-1:0];
                                wk_wdata = {req_reg.block_addr, wr_data};
                                wn_next  = j_reg + WK_CW'(1);
                            end else begin
                                wn_next = j_reg;
                            end
                        end
                        k_next     = '0;
                        pend2_next = 1'b0;
                        scnt_next  = '0;
                        for (int i = 0; i < PATH_LEN; i++) begin
                            fill_next[i] = '0;
                        end
                        state_next = S_EVICT;
                    end
                end
            end
            S_EVICT: begin
                // third stage: place the block using its current leaf
                if (pend2_reg) begin
                    for (int i = 0; i < PATH_LEN; i++) begin
                        if (!placed && fill_reg[i] < FW'(BUCKET_SLOTS)
                            && (pm_rdata >> i) == (prev_leaf_reg >> i)) begin
                            placed = 1'b1;
                            sel    = LVL_W'(i);
                        end
                    end
                    if (placed) begin
                        tr_we          = 1'b1;
                        tr_waddr       = slot_addr(prev_leaf_reg, sel, fill_reg[sel]);
                        tr_wdata       = {1'b1, ev_id_reg, ev_data_reg};
                        fill_next[sel] = fill_reg[sel] + FW'(1);
                    end else if (scnt_reg < ST_CW'(STASH_DEPTH)) begin
                        st_we     = 1'b1;
                        st_waddr  = scnt_reg[ST_AW-1:0];
                        st_wdata  = {ev_id_reg, ev_data_reg};
                        scnt_next = scnt_reg + ST_CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                // second stage: look up the block's leaf
                if (pend_reg) begin
                    pm_raddr     = pm_index(wk_id);
                    ev_id_next   = wk_id;
                    ev_data_next = wk_dat;
                    pend2_next   = 1'b1;
                end else begin
                    pend2_next = 1'b0;
                end
                if (k_reg < wn_reg) begin
                    wk_raddr  = k_reg[WK_AW-1:0];
                    k_next    = k_reg + WK_CW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg && !pend2_reg) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            pend2_reg <= 1'b0;
            scnt_reg  <= '0;
            found_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            rd_reg    <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            pend2_reg <= pend2_next;
            scnt_reg  <= scnt_next;
            found_reg <= found_next;
            ovf_reg   <= ovf_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        prev_leaf_reg <= prev_leaf_next;
        k_reg         <= k_next;
        wn_reg        <= wn_next;
        j_reg         <= j_next;
        lvl_reg       <= lvl_next;
        slot_reg      <= slot_next;
        pdone_reg     <= pdone_next;
        tr_pa_reg     <= tr_pa_next;
        fill_reg      <= fill_next;
        ev_id_reg     <= ev_id_next;
        ev_data_reg   <= ev_data_next;
    end
endmodule
`default_nettype wire

### design/path_oram_controller.sv
// Path ORAM access engine with the bucket tree, position map and stash on chip.
// Input words (s_ channel): s_tuser carries the action (read, write, set
// position map entry, none); s_tdata carries block address, write data and new leaf.
// Result words (m_ channel): one per input word, m_tdata is the read data
// (write data echoed for writes), m_tuser holds found and stash overflow.
// After reset the block sweeps the position map and tree memory, one entry per
// cycle, with s_tready low. Set-entry, no-op and out-of-range words go
// straight from idle to the result. A read or write copies the stashed blocks
// into the work memory, reads the TREE_DEPTH+1 levels of the old path, one
// slot per cycle, scans the work entries and then evicts them back to the
// path or the stash. The tree and work memories each take one read and one
// write per cycle.
// One word is worked on at a time. The result sits in an output register, so
// the next word is accepted while it waits; a stalled m_tready only holds
// the engine once a second result is ready.
`default_nettype none
module path_oram_controller #(
    parameter int TREE_DEPTH   = orm_pkg::DEF_TREE_DEPTH,
    parameter int BUCKET_SLOTS = orm_pkg::DEF_BUCKET_SLOTS,
    parameter int BLOCK_COUNT  = orm_pkg::DEF_BLOCK_COUNT,
    parameter int STASH_DEPTH  = orm_pkg::DEF_STASH_DEPTH,
    parameter int DATA_WIDTH   = orm_pkg::DEF_DATA_WIDTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // block_addr[9:0], write_data[73:10], new_leaf[83:74]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // read_data[63:0]
    output logic [1:0]       m_tuser    // found[0], stash_overflow[1]
);
    import orm_pkg::*;

    orm_req_t req;
    orm_res_t res;
    logic     eng_ready, eng_done, out_free;
    logic     m_valid_reg;
    orm_res_t m_res_reg;

    assign req.action     = s_tuser;
    assign req.block_addr = s_tdata[9:0];
    assign req.write_data = s_tdata[73:10];
    assign req.new_leaf   = s_tdata[83:74];

    assign s_tready = eng_ready;
    assign out_free = !m_valid_reg || m_tready;

    orm_engine #(
        .TREE_DEPTH(TREE_DEPTH), .BUCKET_SLOTS(BUCKET_SLOTS),
        .BLOCK_COUNT(BLOCK_COUNT), .STASH_DEPTH(STASH_DEPTH), .DATA_WIDTH(DATA_WIDTH)
    ) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .start(s_tvalid && eng_ready), .req(req), .ready(eng_ready),
        .out_free(out_free), .done(eng_done), .res(res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eng_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_done) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.read_data;
    assign m_tuser  = {m_res_reg.stash_overflow, m_res_reg.found};
endmodule
`default_nettype wire
